// ===== rtl/cia402_drive_enable_sequencer_top_defines.svh =====
// Assertion helpers for the drive enable sequencer.
`ifndef CIA402_DRIVE_ENABLE_SEQUENCER_TOP_DEFINES_SVH
`define CIA402_DRIVE_ENABLE_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define CDES_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// invariant, checked at every rising edge outside reset
`define CDES_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) 1'b1 |-> (cond)) \
		else $error(msg);

`endif

// ===== rtl/cdes_pkg.sv =====
package cdes_pkg;

	localparam int JOINT_COUNT_DEF = 6;
	localparam int JOINT_IDX_W     = 3;
	localparam int JOINT_SLOTS     = 1 << JOINT_IDX_W;

	localparam logic [15:0] SW_MASK_A   = 16'h004F;
	localparam logic [15:0] SW_MASK_B   = 16'h006F;
	localparam logic [15:0] SW_NOT_RDY  = 16'h0000;
	localparam logic [15:0] SW_SO_DIS   = 16'h0040;
	localparam logic [15:0] SW_RDY      = 16'h0021;
	localparam logic [15:0] SW_SW_ON    = 16'h0023;
	localparam logic [15:0] SW_OP_EN    = 16'h0027;
	localparam logic [15:0] SW_FAULT    = 16'h0008;

	localparam logic [15:0] CW_SHUTDOWN_MASK = 16'h007E;
	localparam logic [15:0] CW_SHUTDOWN_SET  = 16'h0006;
	localparam logic [15:0] CW_SWON_MASK     = 16'h0077;
	localparam logic [15:0] CW_SWON_SET      = 16'h0007;
	localparam logic [15:0] CW_ENOP_MASK     = 16'h007F;
	localparam logic [15:0] CW_ENOP_SET      = 16'h000F;
	localparam logic [15:0] CW_FRST_MASK     = 16'h00FF;
	localparam logic [15:0] CW_FRST_SET      = 16'h0080;

	typedef enum logic [2:0] {
		ST_UNKNOWN        = 3'd0,
		ST_NOT_READY      = 3'd1,
		ST_SW_ON_DISABLED = 3'd2,
		ST_READY          = 3'd3,
		ST_SWITCHED_ON    = 3'd4,
		ST_OP_ENABLED     = 3'd5,
		ST_FAULT          = 3'd6
	} drive_state_t;

	typedef struct packed {
		logic         hit;
		drive_state_t state;
		logic         ctrl_write;
		logic [15:0]  ctrl_value;
		logic         advance;
	} dec_result_t;

	typedef struct packed {
		logic [JOINT_IDX_W-1:0] joint;
		drive_state_t           prev_state;
		logic                   wrap;
	} joint_info_t;

endpackage

// ===== rtl/cia402_drive_enable_sequencer_top.sv =====
// Path: an accepted input word passes the input register, then its result word the result register.
// Throughput: one word per cycle while out_stall is low; decode, control update and joint state
// update all sit between the input register and the result register.
// Reset: arst_n clears the joint pointer, every stored drive state (unknown)
// and both valid flags; payload registers are not reset.
module cia402_drive_enable_sequencer_top
	import cdes_pkg::*;
#(
	parameter int JOINT_COUNT = JOINT_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [15:0]            drv_status,
	input  logic [15:0]            drv_control,
	input  logic signed [31:0]     actual_pos,
	input  logic signed [31:0]     cmd_pos,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [JOINT_IDX_W-1:0] joint_sel,
	output logic                   ctrl_write,
	output logic [15:0]            ctrl_value,
	output logic                   target_write,
	output logic signed [31:0]     target_value,
	output logic [2:0]             drive_state,
	output logic                   all_enabled
);

`include "cia402_drive_enable_sequencer_top_defines.svh"

	logic               valid_s1;
	logic [15:0]        status_s1;
	logic [15:0]        control_s1;
	logic signed [31:0] actual_s1;
	logic signed [31:0] target_s1;

	logic        s2_ready;
	logic        s1_fire;
	logic        in_fire;

	dec_result_t  dec;
	joint_info_t  info;
	drive_state_t new_state;
	logic         tgt_fix;

	assign s2_ready = !out_valid || !out_stall;
	assign s1_fire  = valid_s1 && s2_ready;
	assign in_stall = valid_s1 && !s2_ready;
	assign in_fire  = in_valid && !in_stall;

	cdes_decode u_decode (
		.drv_status  (status_s1),
		.drv_control (control_s1),
		.dec         (dec)
	);

	assign new_state = dec.hit ? dec.state : info.prev_state;
	assign tgt_fix   = dec.hit && (dec.state == ST_SWITCHED_ON)
		&& (info.prev_state != ST_SWITCHED_ON) && (actual_s1 != target_s1);

	cdes_state #(
		.JOINT_COUNT (JOINT_COUNT)
	) u_state (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (s1_fire),
		.next_state (new_state),
		.advance    (dec.advance),
		.info       (info)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			status_s1  <= drv_status;
			control_s1 <= drv_control;
			actual_s1  <= actual_pos;
			target_s1  <= cmd_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s2_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			joint_sel    <= info.joint;
			ctrl_write   <= dec.ctrl_write;
			ctrl_value   <= dec.ctrl_value;
			target_write <= tgt_fix;
			target_value <= tgt_fix ? actual_s1 : 32'sd0;
			drive_state  <= new_state;
			all_enabled  <= dec.advance && info.wrap;
		end
	end

	`CDES_ASSERT_IMP(a_tgt_only_on_switch_on, clk, arst_n, out_valid && target_write,
		ctrl_write && (drive_state == ST_SWITCHED_ON), "target fix outside switched on")
	`CDES_ASSERT_IMP(a_all_en_on_last, clk, arst_n, out_valid && all_enabled,
		(drive_state == ST_OP_ENABLED) && (joint_sel == JOINT_IDX_W'(JOINT_COUNT - 1)),
		"all_enabled not on last joint")
	`CDES_ASSERT_IMP(a_ctrl_zero, clk, arst_n, out_valid && !ctrl_write,
		ctrl_value == 16'h0000, "control value without write")
	`CDES_ASSERT_ALWAYS(a_joint_range, clk, arst_n,
		info.joint < JOINT_IDX_W'(JOINT_COUNT), "joint pointer out of range")

endmodule

// ===== rtl/cdes_decode.sv =====
module cdes_decode
	import cdes_pkg::*;
(
	input  logic [15:0] drv_status,
	input  logic [15:0] drv_control,
	output dec_result_t dec
);

	logic [15:0] sw_a;
	logic [15:0] sw_b;

	assign sw_a = drv_status & SW_MASK_A;
	assign sw_b = drv_status & SW_MASK_B;

	always_comb begin
		dec = '{hit: 1'b0, state: ST_UNKNOWN, ctrl_write: 1'b0,
			ctrl_value: 16'h0000, advance: 1'b0};
		priority if (sw_a == SW_NOT_RDY) begin
			dec.hit   = 1'b1;
			dec.state = ST_NOT_READY;
		end else if (sw_a == SW_SO_DIS) begin
			dec.hit        = 1'b1;
			dec.state      = ST_SW_ON_DISABLED;
			dec.ctrl_write = 1'b1;
			dec.ctrl_value = (drv_control & CW_SHUTDOWN_MASK) | CW_SHUTDOWN_SET;
		end else if (sw_b == SW_RDY) begin
			dec.hit        = 1'b1;
			dec.state      = ST_READY;
			dec.ctrl_write = 1'b1;
			dec.ctrl_value = (drv_control & CW_SWON_MASK) | CW_SWON_SET;
		end else if (sw_b == SW_SW_ON) begin
			dec.hit        = 1'b1;
			dec.state      = ST_SWITCHED_ON;
			dec.ctrl_write = 1'b1;
			dec.ctrl_value = (drv_control & CW_ENOP_MASK) | CW_ENOP_SET;
		end else if (sw_b == SW_OP_EN) begin
			dec.hit     = 1'b1;
			dec.state   = ST_OP_ENABLED;
			dec.advance = 1'b1;
		end else if (sw_a == SW_FAULT) begin
			dec.hit        = 1'b1;
			dec.state      = ST_FAULT;
			dec.ctrl_write = 1'b1;
			dec.ctrl_value = (drv_control & CW_FRST_MASK) | CW_FRST_SET;
		end else begin
			dec.hit = 1'b0;
		end
	end

endmodule

// ===== rtl/cdes_state.sv =====
module cdes_state
	import cdes_pkg::*;
#(
	parameter int JOINT_COUNT = JOINT_COUNT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         upd,
	input  drive_state_t next_state,
	input  logic         advance,
	output joint_info_t  info
);

	localparam logic [JOINT_IDX_W-1:0] LAST_WRAP = JOINT_IDX_W'(JOINT_COUNT);

	logic [JOINT_IDX_W-1:0] joint_q;
	drive_state_t           state_q [JOINT_SLOTS];
	logic [JOINT_IDX_W-1:0] joint_inc;

	assign joint_inc       = joint_q + JOINT_IDX_W'(1);
	assign info.joint      = joint_q;
	assign info.prev_state = state_q[joint_q];
	assign info.wrap       = (joint_inc == LAST_WRAP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joint_q <= '0;
			for (int i = 0; i < JOINT_SLOTS; i++) begin
				state_q[i] <= ST_UNKNOWN;
			end
		end else if (upd) begin
			state_q[joint_q] <= next_state;
			if (advance) begin
				joint_q <= info.wrap ? '0 : joint_inc;
			end
		end
	end

endmodule
